[sv/lrgd_pkg.sv]
package lrgd_pkg;

  localparam int MAX_SAMPLES  = 128;
  localparam int NUM_FEATURES = 5;
  localparam int FEAT_SLOTS   = 5;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int FW     = $clog2(NUM_FEATURES + 1);
  localparam int FI_W   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

  // shared multiplier operand widths
  localparam int MA_W = 49;
  localparam int MB_W = 17;
  localparam int MP_W = MA_W + MB_W;

  localparam logic CFG_LR   = 1'b0;
  localparam logic CFG_ITER = 1'b1;

  localparam logic signed [47:0] E_SQ_LIM  = 48'sh0040_0000_0000;
  localparam logic [63:0]        Q_POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0]        Q_NEG_LIM = 64'h0000_8000_0000_0000;
  localparam logic [63:0]        U48_LIM   = 64'h0000_FFFF_FFFF_FFFF;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [47:0] q32_t;
  typedef q16_t [NUM_FEATURES-1:0] feat_vec_t;

  typedef struct packed {
    logic              ld_we;
    logic              err_we;
    logic [ADDR_W-1:0] addr;
  } st_ctrl_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_INIT,
    ST_PRD_RD, ST_PRD_MUL, ST_PRD_ACC, ST_PRD_WR,
    ST_GRD_RD, ST_GRD_MUL, ST_GRD_ACC, ST_GRD_FOLD,
    ST_GDIV, ST_GWAIT, ST_STEP_MUL, ST_STEP_ADD,
    ST_MSE_RD, ST_MSE_MUL, ST_MSE_ACC, ST_MSE_FOLD,
    ST_MDIV, ST_MWAIT, ST_OUT
  } state_t;

  function automatic logic signed [47:0] sat_s48(input logic signed [63:0] v);
    if (v[63:47] == {17{v[63]}}) return v[47:0];
    return v[63] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
  endfunction

  function automatic logic signed [31:0] sat_s32(input logic signed [49:0] v);
    if (v[49:31] == {19{v[49]}}) return v[31:0];
    return v[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [63:0] sat_add_s64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63]))
      return a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  function automatic logic [63:0] sat_add_u64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

[sv/lrgd_mult.sv]
module lrgd_mult (
  input  logic                               clk,
  input  logic signed [lrgd_pkg::MA_W-1:0]   a,
  input  logic signed [lrgd_pkg::MB_W-1:0]   b,
  output logic signed [lrgd_pkg::MP_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

[sv/lrgd_div.sv]
module lrgd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [63:0]                 dividend,
  input  logic [lrgd_pkg::CNT_W-1:0]  divisor,
  output logic                        done_r,
  output logic [63:0]                 quo_r
);

  localparam int CW = lrgd_pkg::CNT_W;

  logic [CW:0]   rem_r;
  logic [CW-1:0] dvs_r;
  logic [5:0]    bit_r;
  logic          busy_r;
  logic [CW:0]   rem_sh;
  logic          take;

  always_comb begin
    rem_sh = {rem_r[CW-1:0], quo_r[63]};
    take   = rem_sh >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        bit_r  <= '0;
      end else if (busy_r) begin
        bit_r <= bit_r + 1'b1;
        if (bit_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_r <= {quo_r[62:0], take};
    end
  end

endmodule

[sv/lrgd_store.sv]
module lrgd_store (
  input  logic                  clk,
  input  lrgd_pkg::st_ctrl_t    ctrl,
  input  lrgd_pkg::feat_vec_t   wr_x,
  input  lrgd_pkg::q16_t        wr_t,
  input  lrgd_pkg::q32_t        wr_e,
  output lrgd_pkg::feat_vec_t   rd_x_r,
  output lrgd_pkg::q16_t        rd_t_r,
  output lrgd_pkg::q32_t        rd_e_r
);

  localparam int NF = lrgd_pkg::NUM_FEATURES;
  localparam int MS = lrgd_pkg::MAX_SAMPLES;

  lrgd_pkg::q16_t feat_mem [NF][MS];
  lrgd_pkg::q16_t tgt_mem  [MS];
  lrgd_pkg::q32_t err_mem  [MS];

  always_ff @(posedge clk) begin
    for (int f = 0; f < NF; f++) begin
      if (ctrl.ld_we) feat_mem[f][ctrl.addr] <= wr_x[f];
      rd_x_r[f] <= feat_mem[f][ctrl.addr];
    end
    if (ctrl.ld_we) tgt_mem[ctrl.addr] <= wr_t;
    rd_t_r <= tgt_mem[ctrl.addr];
    if (ctrl.err_we) err_mem[ctrl.addr] <= wr_e;
    rd_e_r <= err_mem[ctrl.addr];
  end

endmodule

[sv/linear_regression_gd_trainer.sv]
// Batch gradient descent trainer for a linear model, signed Q16.16 data.
// Input channel (in_valid / in_stall): one training sample per transfer,
// features in_x0..in_x4 and in_target. A sample is taken whenever in_valid
// is high while the block is loading; samples past the store depth are dropped.
// The transfer with in_last set starts training on the samples held, and
// in_stall stays high until the result has been taken.
// Training runs iterations+1 passes on one shared 49x17 multiplier, two
// accumulators and a bit-serial divider, which forms each mean; a final
// sweep over the samples then gives the mean squared error.
// Output channel (out_valid / out_stall): one result per batch, held in
// registers; while out_stall is high the result and in_stall both hold.
// After the result transfer the block loads a new batch.
// cfg_we/cfg_idx/cfg_wdata write learning_rate (index 0) and iterations
// (index 1); write them only while the block is loading and empty.
// Synchronous reset: learning_rate 655, iterations 1000, empty batch.
module linear_regression_gd_trainer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_x0,
  input  logic signed [31:0]  in_x1,
  input  logic signed [31:0]  in_x2,
  input  logic signed [31:0]  in_x3,
  input  logic signed [31:0]  in_x4,
  input  logic signed [31:0]  in_target,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_w0,
  output logic signed [31:0]  out_w1,
  output logic signed [31:0]  out_w2,
  output logic signed [31:0]  out_w3,
  output logic signed [31:0]  out_w4,
  output logic signed [31:0]  out_bias_out,
  output logic [47:0]         out_mean_sq_error
);

  localparam int NF    = lrgd_pkg::NUM_FEATURES;
  localparam int CW    = lrgd_pkg::CNT_W;
  localparam int AW    = lrgd_pkg::ADDR_W;
  localparam int FWD   = lrgd_pkg::FW;
  localparam int FIW   = lrgd_pkg::FI_W;
  localparam int SLOTS = lrgd_pkg::FEAT_SLOTS;

  lrgd_pkg::state_t state_r, state_nxt;

  logic [15:0]         lr_r, it_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       s_r, s_nxt;
  logic [FWD-1:0]      f_r, f_nxt;
  logic [1:0]          c_r, c_nxt;
  logic [16:0]         pass_r, pass_nxt;
  logic signed [63:0]  tmp_r, tmp_nxt, acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic signed [47:0]  grad_r, grad_nxt;
  lrgd_pkg::q16_t      w_r [NF];
  lrgd_pkg::q16_t      w_nxt [NF];
  lrgd_pkg::q16_t      bias_r, bias_nxt;
  logic [47:0]         mse_r, mse_nxt;

  lrgd_pkg::st_ctrl_t  st_ctrl;
  lrgd_pkg::feat_vec_t wr_x, rd_x;
  lrgd_pkg::q16_t      rd_t;
  lrgd_pkg::q32_t      rd_e, wr_e;

  logic signed [lrgd_pkg::MA_W-1:0] mul_a;
  logic signed [lrgd_pkg::MB_W-1:0] mul_b;
  logic signed [lrgd_pkg::MP_W-1:0] prod;
  logic signed [lrgd_pkg::MP_W-1:0] prod_fl;

  logic        div_start, div_done;
  logic [63:0] div_dvd, div_quo;

  lrgd_pkg::q16_t in_all [SLOTS];
  lrgd_pkg::q16_t w_all  [SLOTS];
  lrgd_pkg::q16_t cur_x, cur_w, old_v;

  logic        in_xfer, s_last, f_is_bias, e_big;
  logic signed [63:0] term;
  logic signed [49:0] step_sum;

  assign in_all[0] = in_x0;
  assign in_all[1] = in_x1;
  assign in_all[2] = in_x2;
  assign in_all[3] = in_x3;
  assign in_all[4] = in_x4;

  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    if (g < NF) begin : g_used
      assign wr_x[g]  = in_all[g];
      assign w_all[g] = w_r[g];
    end else begin : g_unused
      assign w_all[g] = '0;
    end
  end

  assign out_w0       = w_all[0];
  assign out_w1       = w_all[1];
  assign out_w2       = w_all[2];
  assign out_w3       = w_all[3];
  assign out_w4       = w_all[4];
  assign out_bias_out = bias_r;
  assign out_mean_sq_error = mse_r;
  assign out_valid    = (state_r == lrgd_pkg::ST_OUT);
  assign in_stall     = (state_r != lrgd_pkg::ST_LOAD);
  assign in_xfer      = in_valid && !in_stall;

  lrgd_store u_store (
    .clk    (clk),
    .ctrl   (st_ctrl),
    .wr_x   (wr_x),
    .wr_t   (in_target),
    .wr_e   (wr_e),
    .rd_x_r (rd_x),
    .rd_t_r (rd_t),
    .rd_e_r (rd_e)
  );

  lrgd_mult u_mult (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  lrgd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (cnt_r),
    .done_r   (div_done),
    .quo_r    (div_quo)
  );

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= 16'd655;
      it_r <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lrgd_pkg::CFG_LR:   lr_r <= cfg_wdata;
        lrgd_pkg::CFG_ITER: it_r <= cfg_wdata;
      endcase
    end
  end

  always_comb begin
    cur_x     = rd_x[f_r[FIW-1:0]];
    cur_w     = w_r[f_r[FIW-1:0]];
    s_last    = (CW'(s_r) == cnt_r - 1'b1);
    f_is_bias = (f_r == FWD'(NF));
    e_big     = (rd_e >= lrgd_pkg::E_SQ_LIM) || (rd_e <= -lrgd_pkg::E_SQ_LIM);
    prod_fl   = prod >>> 16;
    old_v     = f_is_bias ? bias_r : cur_w;
    step_sum  = 50'(old_v) + 50'($signed(prod_fl[47:0]));
    wr_e      = lrgd_pkg::sat_s48(64'(rd_t) - tmp_r);
    // chunk 0: floored, chunk 1: as is, chunk 2: shifted up (squares only)
    unique case (c_r)
      2'd0:    term = prod_fl[63:0];
      2'd1:    term = prod[63:0];
      default: term = {prod[47:0], 16'b0};
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      lrgd_pkg::ST_PRD_MUL: begin
        mul_a = 49'(cur_x);
        mul_b = (c_r == 2'd0) ? {1'b0, cur_w[15:0]} : {cur_w[31], cur_w[31:16]};
      end
      lrgd_pkg::ST_GRD_MUL: begin
        mul_a = 49'(rd_e);
        mul_b = (c_r == 2'd0) ? {1'b0, cur_x[15:0]} : {cur_x[31], cur_x[31:16]};
      end
      lrgd_pkg::ST_MSE_MUL: begin
        mul_a = 49'(rd_e);
        unique case (c_r)
          2'd0:    mul_b = {1'b0, rd_e[15:0]};
          2'd1:    mul_b = {1'b0, rd_e[31:16]};
          default: mul_b = {rd_e[47], rd_e[47:32]};
        endcase
      end
      lrgd_pkg::ST_STEP_MUL: begin
        mul_a = 49'(grad_r);
        mul_b = {1'b0, lr_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    s_nxt     = s_r;
    f_nxt     = f_r;
    c_nxt     = c_r;
    pass_nxt  = pass_r;
    tmp_nxt   = tmp_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    grad_nxt  = grad_r;
    w_nxt     = w_r;
    bias_nxt  = bias_r;
    mse_nxt   = mse_r;
    div_start = 1'b0;
    div_dvd   = acc_r;
    st_ctrl.ld_we  = 1'b0;
    st_ctrl.err_we = 1'b0;
    st_ctrl.addr   = s_r;

    unique case (state_r)
      lrgd_pkg::ST_LOAD: begin
        st_ctrl.addr = cnt_r[AW-1:0];
        if (in_xfer) begin
          if (cnt_r < CW'(lrgd_pkg::MAX_SAMPLES)) begin
            st_ctrl.ld_we = 1'b1;
            cnt_nxt       = cnt_r + 1'b1;
          end
          if (in_last) state_nxt = lrgd_pkg::ST_INIT;
        end
      end
      lrgd_pkg::ST_INIT: begin
        for (int i = 0; i < NF; i++) w_nxt[i] = '0;
        bias_nxt  = '0;
        pass_nxt  = '0;
        s_nxt     = '0;
        state_nxt = lrgd_pkg::ST_PRD_RD;
      end
      lrgd_pkg::ST_PRD_RD: begin
        tmp_nxt   = 64'(bias_r);
        f_nxt     = '0;
        c_nxt     = '0;
        state_nxt = lrgd_pkg::ST_PRD_MUL;
      end
      lrgd_pkg::ST_PRD_MUL: state_nxt = lrgd_pkg::ST_PRD_ACC;
      lrgd_pkg::ST_PRD_ACC: begin
        tmp_nxt = tmp_r + term;
        if (c_r == 2'd0) begin
          c_nxt     = 2'd1;
          state_nxt = lrgd_pkg::ST_PRD_MUL;
        end else begin
          c_nxt = 2'd0;
          if (f_r == FWD'(NF - 1)) begin
            state_nxt = lrgd_pkg::ST_PRD_WR;
          end else begin
            f_nxt     = f_r + 1'b1;
            state_nxt = lrgd_pkg::ST_PRD_MUL;
          end
        end
      end
      lrgd_pkg::ST_PRD_WR: begin
        st_ctrl.err_we = 1'b1;
        if (s_last) begin
          s_nxt     = '0;
          f_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = lrgd_pkg::ST_GRD_RD;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = lrgd_pkg::ST_PRD_RD;
        end
      end
      lrgd_pkg::ST_GRD_RD: begin
        tmp_nxt   = '0;
        c_nxt     = '0;
        state_nxt = f_is_bias ? lrgd_pkg::ST_GRD_FOLD : lrgd_pkg::ST_GRD_MUL;
      end
      lrgd_pkg::ST_GRD_MUL: state_nxt = lrgd_pkg::ST_GRD_ACC;
      lrgd_pkg::ST_GRD_ACC: begin
        tmp_nxt = tmp_r + term;
        if (c_r == 2'd0) begin
          c_nxt     = 2'd1;
          state_nxt = lrgd_pkg::ST_GRD_MUL;
        end else begin
          state_nxt = lrgd_pkg::ST_GRD_FOLD;
        end
      end
      lrgd_pkg::ST_GRD_FOLD: begin
        acc_nxt = lrgd_pkg::sat_add_s64(acc_r, f_is_bias ? 64'(rd_e) : tmp_r);
        if (s_last) begin
          state_nxt = lrgd_pkg::ST_GDIV;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = lrgd_pkg::ST_GRD_RD;
        end
      end
      lrgd_pkg::ST_GDIV: begin
        div_start = 1'b1;
        div_dvd   = acc_r[63] ? 64'(-acc_r) : acc_r;
        neg_nxt   = acc_r[63];
        state_nxt = lrgd_pkg::ST_GWAIT;
      end
      lrgd_pkg::ST_GWAIT: begin
        if (div_done) begin
          if (neg_r)
            grad_nxt = (div_quo > lrgd_pkg::Q_NEG_LIM) ? 48'sh8000_0000_0000
                                                        : -div_quo[47:0];
          else
            grad_nxt = (div_quo > lrgd_pkg::Q_POS_LIM) ? 48'sh7FFF_FFFF_FFFF
                                                        : div_quo[47:0];
          state_nxt = lrgd_pkg::ST_STEP_MUL;
        end
      end
      lrgd_pkg::ST_STEP_MUL: state_nxt = lrgd_pkg::ST_STEP_ADD;
      lrgd_pkg::ST_STEP_ADD: begin
        s_nxt   = '0;
        acc_nxt = '0;
        if (f_is_bias) begin
          bias_nxt = lrgd_pkg::sat_s32(step_sum);
          if (pass_r == 17'(it_r)) begin
            state_nxt = lrgd_pkg::ST_MSE_RD;
          end else begin
            pass_nxt  = pass_r + 1'b1;
            state_nxt = lrgd_pkg::ST_PRD_RD;
          end
        end else begin
          w_nxt[f_r[FIW-1:0]] = lrgd_pkg::sat_s32(step_sum);
          f_nxt     = f_r + 1'b1;
          state_nxt = lrgd_pkg::ST_GRD_RD;
        end
      end
      lrgd_pkg::ST_MSE_RD: begin
        tmp_nxt   = '0;
        c_nxt     = '0;
        state_nxt = lrgd_pkg::ST_MSE_MUL;
      end
      lrgd_pkg::ST_MSE_MUL: state_nxt = lrgd_pkg::ST_MSE_ACC;
      lrgd_pkg::ST_MSE_ACC: begin
        tmp_nxt = tmp_r + term;
        if (c_r == 2'd2) begin
          state_nxt = lrgd_pkg::ST_MSE_FOLD;
        end else begin
          c_nxt     = c_r + 1'b1;
          state_nxt = lrgd_pkg::ST_MSE_MUL;
        end
      end
      lrgd_pkg::ST_MSE_FOLD: begin
        // large errors saturate their square term
        acc_nxt = lrgd_pkg::sat_add_u64(acc_r, e_big ? {64{1'b1}} : tmp_r);
        if (s_last) begin
          state_nxt = lrgd_pkg::ST_MDIV;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = lrgd_pkg::ST_MSE_RD;
        end
      end
      lrgd_pkg::ST_MDIV: begin
        div_start = 1'b1;
        state_nxt = lrgd_pkg::ST_MWAIT;
      end
      lrgd_pkg::ST_MWAIT: begin
        if (div_done) begin
          mse_nxt   = (div_quo > lrgd_pkg::U48_LIM) ? 48'hFFFF_FFFF_FFFF : div_quo[47:0];
          state_nxt = lrgd_pkg::ST_OUT;
        end
      end
      lrgd_pkg::ST_OUT: begin
        if (!out_stall) begin
          cnt_nxt   = '0;
          state_nxt = lrgd_pkg::ST_LOAD;
        end
      end
      default: state_nxt = lrgd_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrgd_pkg::ST_LOAD;
      cnt_r   <= '0;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    f_r    <= f_nxt;
    c_r    <= c_nxt;
    tmp_r  <= tmp_nxt;
    acc_r  <= acc_nxt;
    neg_r  <= neg_nxt;
    grad_r <= grad_nxt;
    w_r    <= w_nxt;
    bias_r <= bias_nxt;
    mse_r  <= mse_nxt;
  end

endmodule
